[rtl/ssht_pkg.sv]
// Shared constants and types for the segment-versus-sphere hit test.
`timescale 1ns / 1ps

package ssht_pkg;

   // Default coordinate width: Q8.8 in 16 bits.
   localparam int COORD_WIDTH_DEF = 16;

   // Which point of the segment is compared with the sphere.
   typedef enum logic [1:0] {
      REGION_START,
      REGION_END,
      REGION_INSIDE
   } region_type;

endpackage

[rtl/segment_sphere_hit_test.sv]
// Pipelined segment-versus-sphere hit test.
`timescale 1ns / 1ps

// Usage:
// The request channel carries one query: segment start and end, sphere centre and radius,
// all as two's complement fixed point of COORD_WIDTH bits (radius one bit narrower,
// unsigned). The response channel returns one hit bit per request, in request order,
// set when the point of the segment nearest the centre lies within or on the sphere.
// Both channels use valid and stall; a transfer happens on a clock edge with valid high
// and stall low.
// One request can be taken in every cycle while req_stall is low, so throughput is one
// query per clock when nothing stalls. The six register stages are the coordinate
// differences, the products, the sums of squares and dot product, the split partial
// products of the wide multiplications, their recombination, and the final compare held
// in the output register.
// When the receiver stalls, the result waits in the output register and the pipeline
// keeps taking requests until every stage holds one; req_stall then rises.
// A synchronous reset empties every stage; no query is in flight afterwards.
module segment_sphere_hit_test
   import ssht_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_WIDTH-1:0] req_start_x,
   input  logic [COORD_WIDTH-1:0] req_start_y,
   input  logic [COORD_WIDTH-1:0] req_start_z,
   input  logic [COORD_WIDTH-1:0] req_end_x,
   input  logic [COORD_WIDTH-1:0] req_end_y,
   input  logic [COORD_WIDTH-1:0] req_end_z,
   input  logic [COORD_WIDTH-1:0] req_center_x,
   input  logic [COORD_WIDTH-1:0] req_center_y,
   input  logic [COORD_WIDTH-1:0] req_center_z,
   input  logic [COORD_WIDTH-2:0] req_radius,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;       // coordinate difference
   localparam int RW = W - 1;       // radius
   localparam int P  = 2 * DW;      // products and sums of squares
   localparam int TW = P + 1;       // signed dot product
   localparam int H  = P / 2;       // half operand for the split multipliers
   localparam int QW = 2 * P + 1;   // full wide products and their sum

   localparam int PROD_WWDD = 0;
   localparam int PROD_RRDD = 1;
   localparam int PROD_TT   = 2;

   // Stage enables: a stage may load when it is empty or its successor loads.
   logic en1, en2, en3, en4, en5, en6;

   // Stage 1: differences.
   logic                 s1_valid_ff;
   logic signed [DW-1:0] s1_d_ff [3];
   logic signed [DW-1:0] s1_w_ff [3];
   logic signed [DW-1:0] s1_v_ff [3];
   logic        [RW-1:0] s1_r_ff;
   logic signed [DW-1:0] s1_d_in [3];
   logic signed [DW-1:0] s1_w_in [3];
   logic signed [DW-1:0] s1_v_in [3];
   logic        [W-1:0]  pt_s [3];
   logic        [W-1:0]  pt_e [3];
   logic        [W-1:0]  pt_c [3];

   // Stage 2: per-component products.
   logic                 s2_valid_ff;
   logic        [P-1:0]  s2_dd_ff [3];
   logic        [P-1:0]  s2_ww_ff [3];
   logic        [P-1:0]  s2_vv_ff [3];
   logic signed [P-1:0]  s2_wd_ff [3];
   logic        [2*RW-1:0] s2_rr_ff;
   logic signed [P-1:0]  s2_dd_in [3];
   logic signed [P-1:0]  s2_ww_in [3];
   logic signed [P-1:0]  s2_vv_in [3];
   logic signed [P-1:0]  s2_wd_in [3];

   // Stage 3: sums.
   logic                 s3_valid_ff;
   logic        [P-1:0]  s3_dd_ff;
   logic        [P-1:0]  s3_ww_ff;
   logic        [P-1:0]  s3_vv_ff;
   logic        [P-1:0]  s3_rr_ff;
   logic signed [TW-1:0] s3_t_ff;
   logic signed [TW-1:0] s3_t_in;

   // Stage 4: partial products and region choice.
   logic                 s4_valid_ff;
   logic        [P-1:0]  s4_hh_ff [3];
   logic        [P-1:0]  s4_hl_ff [3];
   logic        [P-1:0]  s4_lh_ff [3];
   logic        [P-1:0]  s4_ll_ff [3];
   region_type           s4_region_ff;
   logic                 s4_start_in_ff;
   logic                 s4_end_in_ff;
   logic        [P-1:0]  op_a [3];
   logic        [P-1:0]  op_b [3];
   region_type           s4_region_in;

   // Stage 5: recombined wide products.
   logic                 s5_valid_ff;
   logic        [QW-1:0] s5_lhs_ff;
   logic        [QW-1:0] s5_rhs_ff;
   region_type           s5_region_ff;
   logic                 s5_start_in_ff;
   logic                 s5_end_in_ff;
   logic        [QW-1:0] prod [3];

   // Stage 6: output register.
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_hit_in;

   assign en6 = !rsp_valid_ff || !rsp_stall;
   assign en5 = !s5_valid_ff || en6;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_stall = !en1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      pt_s[0] = req_start_x;
      pt_s[1] = req_start_y;
      pt_s[2] = req_start_z;
      pt_e[0] = req_end_x;
      pt_e[1] = req_end_y;
      pt_e[2] = req_end_z;
      pt_c[0] = req_center_x;
      pt_c[1] = req_center_y;
      pt_c[2] = req_center_z;
      for (int k = 0; k < 3; k++) begin
         s1_d_in[k] = {pt_e[k][W-1], pt_e[k]} - {pt_s[k][W-1], pt_s[k]};
         s1_w_in[k] = {pt_c[k][W-1], pt_c[k]} - {pt_s[k][W-1], pt_s[k]};
         s1_v_in[k] = {pt_c[k][W-1], pt_c[k]} - {pt_e[k][W-1], pt_e[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int k = 0; k < 3; k++) begin
            s1_d_ff[k] <= s1_d_in[k];
            s1_w_ff[k] <= s1_w_in[k];
            s1_v_ff[k] <= s1_v_in[k];
         end
         s1_r_ff <= req_radius;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_dd_in[k] = s1_d_ff[k] * s1_d_ff[k];
         s2_ww_in[k] = s1_w_ff[k] * s1_w_ff[k];
         s2_vv_in[k] = s1_v_ff[k] * s1_v_ff[k];
         s2_wd_in[k] = s1_w_ff[k] * s1_d_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int k = 0; k < 3; k++) begin
            s2_dd_ff[k] <= s2_dd_in[k];
            s2_ww_ff[k] <= s2_ww_in[k];
            s2_vv_ff[k] <= s2_vv_in[k];
            s2_wd_ff[k] <= s2_wd_in[k];
         end
         s2_rr_ff <= s1_r_ff * s1_r_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Squares are non-negative and three of them stay below four times the
   // largest, so the sums fit without a carry bit.
   assign s3_t_in = {s2_wd_ff[0][P-1], s2_wd_ff[0]}
                  + {s2_wd_ff[1][P-1], s2_wd_ff[1]}
                  + {s2_wd_ff[2][P-1], s2_wd_ff[2]};

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_dd_ff <= s2_dd_ff[0] + s2_dd_ff[1] + s2_dd_ff[2];
         s3_ww_ff <= s2_ww_ff[0] + s2_ww_ff[1] + s2_ww_ff[2];
         s3_vv_ff <= s2_vv_ff[0] + s2_vv_ff[1] + s2_vv_ff[2];
         s3_rr_ff <= P'(s2_rr_ff);
         s3_t_ff  <= s3_t_in;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // Only the interior case uses the wide products, and there the dot
   // product is positive and below the squared length, so it fits P bits.
   always_comb begin
      op_a[PROD_WWDD] = s3_ww_ff;
      op_b[PROD_WWDD] = s3_dd_ff;
      op_a[PROD_RRDD] = s3_rr_ff;
      op_b[PROD_RRDD] = s3_dd_ff;
      op_a[PROD_TT]   = s3_t_ff[P-1:0];
      op_b[PROD_TT]   = s3_t_ff[P-1:0];

      if (s3_dd_ff == '0 || s3_t_ff[TW-1] || s3_t_ff == '0) begin
         s4_region_in = REGION_START;
      end else if (s3_t_ff >= $signed({1'b0, s3_dd_ff})) begin
         s4_region_in = REGION_END;
      end else begin
         s4_region_in = REGION_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         for (int k = 0; k < 3; k++) begin
            s4_hh_ff[k] <= op_a[k][P-1:H] * op_b[k][P-1:H];
            s4_hl_ff[k] <= op_a[k][P-1:H] * op_b[k][H-1:0];
            s4_lh_ff[k] <= op_a[k][H-1:0] * op_b[k][P-1:H];
            s4_ll_ff[k] <= op_a[k][H-1:0] * op_b[k][H-1:0];
         end
         s4_region_ff   <= s4_region_in;
         s4_start_in_ff <= (s3_ww_ff <= s3_rr_ff);
         s4_end_in_ff   <= (s3_vv_ff <= s3_rr_ff);
      end
   end

   // ---------------------------------------------------------------- stage 5
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = (QW'(s4_hh_ff[k]) << P)
                 + (QW'(s4_hl_ff[k]) << H)
                 + (QW'(s4_lh_ff[k]) << H)
                 + QW'(s4_ll_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_lhs_ff      <= prod[PROD_WWDD];
         s5_rhs_ff      <= prod[PROD_RRDD] + prod[PROD_TT];
         s5_region_ff   <= s4_region_ff;
         s5_start_in_ff <= s4_start_in_ff;
         s5_end_in_ff   <= s4_end_in_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6
   always_comb begin
      unique case (s5_region_ff)
         REGION_START:  rsp_hit_in = s5_start_in_ff;
         REGION_END:    rsp_hit_in = s5_end_in_ff;
         REGION_INSIDE: rsp_hit_in = (s5_lhs_ff <= s5_rhs_ff);
         default:       rsp_hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   // ---------------------------------------------------------------- valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= req_valid;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) s4_valid_ff  <= s3_valid_ff;
         if (en5) s5_valid_ff  <= s4_valid_ff;
         if (en6) rsp_valid_ff <= s5_valid_ff;
      end
   end

endmodule
